// ----- sv/spq_pkg.sv -----
`default_nettype none
package spq_pkg;

	localparam int DATA_W = 32;
	localparam int OCC_W  = 5;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_REMOVE  = 2'd1,
		OP_READOUT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_ROTATE = 2'd3
	} cell_cmd_t;

	typedef enum logic {
		S_IDLE    = 1'b0,
		S_READOUT = 1'b1
	} state_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_cmd_t                 cmd;
		logic signed [DATA_W-1:0]  new_value;
		logic signed [DATA_W-1:0]  new_priority;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- sv/spq_cell.sv -----
`default_nettype none
module spq_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 5
) (
	input  wire                                 clk,
	input  wire spq_pkg::cell_ctl_t             ctl,
	input  wire [CW-1:0]                        count,
	input  wire logic signed [spq_pkg::DATA_W-1:0] left_value,
	input  wire logic signed [spq_pkg::DATA_W-1:0] left_priority,
	input  wire                                 left_le,
	input  wire logic signed [spq_pkg::DATA_W-1:0] right_value,
	input  wire logic signed [spq_pkg::DATA_W-1:0] right_priority,
	input  wire logic signed [spq_pkg::DATA_W-1:0] head_value,
	input  wire logic signed [spq_pkg::DATA_W-1:0] head_priority,
	output logic signed [spq_pkg::DATA_W-1:0]      value,
	output logic signed [spq_pkg::DATA_W-1:0]      priority_o,
	output logic                                le
);

	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic signed [spq_pkg::DATA_W-1:0] value_q;
	logic signed [spq_pkg::DATA_W-1:0] priority_q;
	logic                              occupied;
	logic                              tail;

	assign occupied   = IDX < count;
	assign tail       = IDX == (count - CW'(1));
	// entry stays ahead of a new one of equal priority
	assign le         = occupied && (priority_q <= ctl.new_priority);
	assign value      = value_q;
	assign priority_o = priority_q;

	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			spq_pkg::CMD_HOLD: begin
				value_q    <= value_q;
				priority_q <= priority_q;
			end
			spq_pkg::CMD_INSERT: begin
				if (le) begin
					value_q    <= value_q;
					priority_q <= priority_q;
				end else if (left_le) begin
					value_q    <= ctl.new_value;
					priority_q <= ctl.new_priority;
				end else begin
					value_q    <= left_value;
					priority_q <= left_priority;
				end
			end
			spq_pkg::CMD_REMOVE: begin
				value_q    <= right_value;
				priority_q <= right_priority;
			end
			spq_pkg::CMD_ROTATE: begin
				if (tail) begin
					value_q    <= head_value;
					priority_q <= head_priority;
				end else begin
					value_q    <= right_value;
					priority_q <= right_priority;
				end
			end
			default: begin
				value_q    <= value_q;
				priority_q <= priority_q;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/sorted_priority_queue_core.sv -----
`default_nettype none
// Sorted priority queue of CAPACITY (value, priority) entries held in a chain of
// cells, head in cell 0; a smaller priority is served first and equal priorities
// keep arrival order. On insert each cell compares its priority with the new one
// and keeps its entry, takes the new one or shifts from its left neighbour; on
// remove each shifts from its right neighbour, all in the same edge. A readout
// rotates the occupied cells once per result, one per stored entry, and takes no
// item until its last result is loaded. A full output register decouples
// the result side; a stalled result holds the input off only once it is full.
module sorted_priority_queue_core #(
	parameter int CAPACITY = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire [1:0]                         operation,
	input  wire logic signed [spq_pkg::DATA_W-1:0] item_value,
	input  wire logic signed [spq_pkg::DATA_W-1:0] item_priority,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [1:0]                        status,
	output logic signed [spq_pkg::DATA_W-1:0] out_value,
	output logic signed [spq_pkg::DATA_W-1:0] out_priority,
	output logic                              last,
	output logic [spq_pkg::OCC_W-1:0]         occupancy
);

	localparam int CW = $clog2(CAPACITY + 1);

	spq_pkg::state_t   state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     rd_idx_q, rd_idx_d;
	spq_pkg::cell_ctl_t ctl;
	spq_pkg::cell_cmd_t cell_cmd;

	logic accept, load_ok, load, empty, full, rd_last, multi_readout;
	spq_pkg::op_t op;

	logic signed [spq_pkg::DATA_W-1:0] cell_value [CAPACITY];
	logic signed [spq_pkg::DATA_W-1:0] cell_priority [CAPACITY];
	logic                              cell_le [CAPACITY];

	spq_pkg::status_t                  res_status;
	logic signed [spq_pkg::DATA_W-1:0] res_value, res_priority;
	logic                              res_last;

	logic                              out_valid_q;
	logic [1:0]                        status_q;
	logic signed [spq_pkg::DATA_W-1:0] out_value_q, out_priority_q;
	logic                              last_q;
	logic [spq_pkg::OCC_W-1:0]         occupancy_q;

	assign op            = spq_pkg::op_t'(operation);
	assign load_ok       = !out_valid_q || !out_stall;
	assign in_stall      = (state_q != spq_pkg::S_IDLE) || !load_ok;
	assign accept        = in_valid && !in_stall;
	assign empty         = count_q == '0;
	assign full          = count_q == CW'(CAPACITY);
	assign rd_last       = rd_idx_q == (count_q - CW'(1));
	assign multi_readout = (op == spq_pkg::OP_READOUT) && (count_q > CW'(1));

	// command, new value, new priority
	assign ctl = {cell_cmd, item_value, item_priority};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				if (accept && multi_readout) state_d = spq_pkg::S_READOUT;
			end
			spq_pkg::S_READOUT: begin
				if (load_ok && rd_last) state_d = spq_pkg::S_IDLE;
			end
			default: state_d = spq_pkg::S_IDLE;
		endcase
	end

	// cell command and result
	always_comb begin
		cell_cmd     = spq_pkg::CMD_HOLD;
		load         = 1'b0;
		res_status   = spq_pkg::ST_OK;
		res_value    = '0;
		res_priority = '0;
		res_last     = 1'b1;
		count_d      = count_q;
		rd_idx_d     = rd_idx_q;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				if (accept) begin
					load = 1'b1;
					unique case (op)
						spq_pkg::OP_INSERT: begin
							if (full) begin
								res_status = spq_pkg::ST_FULL;
							end else begin
								cell_cmd = spq_pkg::CMD_INSERT;
								count_d  = count_q + CW'(1);
							end
						end
						spq_pkg::OP_REMOVE: begin
							if (empty) begin
								res_status = spq_pkg::ST_EMPTY;
							end else begin
								cell_cmd     = spq_pkg::CMD_REMOVE;
								res_value    = cell_value[0];
								res_priority = cell_priority[0];
								count_d      = count_q - CW'(1);
							end
						end
						spq_pkg::OP_READOUT: begin
							if (empty) begin
								res_status = spq_pkg::ST_EMPTY;
							end else begin
								cell_cmd     = spq_pkg::CMD_ROTATE;
								res_value    = cell_value[0];
								res_priority = cell_priority[0];
								res_last     = count_q == CW'(1);
								rd_idx_d     = CW'(1);
							end
						end
						default: begin
							// unknown operation leaves the cells unchanged but still gives an OK result
						end
					endcase
				end
			end
			spq_pkg::S_READOUT: begin
				if (load_ok) begin
					load         = 1'b1;
					cell_cmd     = spq_pkg::CMD_ROTATE;
					res_value    = cell_value[0];
					res_priority = cell_priority[0];
					res_last     = rd_last;
					rd_idx_d     = rd_idx_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spq_pkg::S_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			rd_idx_q <= rd_idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q       <= res_status;
			out_value_q    <= res_value;
			out_priority_q <= res_priority;
			last_q         <= res_last;
			occupancy_q    <= spq_pkg::OCC_W'(count_d);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_value    = out_value_q;
	assign out_priority = out_priority_q;
	assign last         = last_q;
	assign occupancy    = occupancy_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [spq_pkg::DATA_W-1:0] lv, lp, rv, rp;
		logic                              lle;
		if (i == 0) begin : g_first
			assign lv  = item_value;
			assign lp  = item_priority;
			assign lle = 1'b1;
		end else begin : g_mid
			assign lv  = cell_value[i-1];
			assign lp  = cell_priority[i-1];
			assign lle = cell_le[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign rv = cell_value[i];
			assign rp = cell_priority[i];
		end else begin : g_inner
			assign rv = cell_value[i+1];
			assign rp = cell_priority[i+1];
		end
		spq_cell #(
			.INDEX(i),
			.CW   (CW)
		) u_cell (
			.clk           (clk),
			.ctl           (ctl),
			.count         (count_q),
			.left_value    (lv),
			.left_priority (lp),
			.left_le       (lle),
			.right_value   (rv),
			.right_priority(rp),
			.head_value    (cell_value[0]),
			.head_priority (cell_priority[0]),
			.value         (cell_value[i]),
			.priority_o    (cell_priority[i]),
			.le            (cell_le[i])
		);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_count_only_on_item: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("entry count moved without an item");

	a_readout_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spq_pkg::S_READOUT |-> (rd_idx_q < count_q) && (rd_idx_q != '0))
		else $error("readout index outside stored entries");

	a_readout_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spq_pkg::S_READOUT |-> in_stall)
		else $error("item taken during readout");

endmodule
`default_nettype wire
